// ===== rtl/path_interpolate_nearest_waypoint_defines.svh =====
// assertion helpers for the top-level rtl
`ifndef PATH_INTERPOLATE_NEAREST_WAYPOINT_DEFINES_SVH
`define PATH_INTERPOLATE_NEAREST_WAYPOINT_DEFINES_SVH

// condition implies consequence in the same cycle
`define WPI_ASSERT_NOW(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("wpi check failed");

// condition implies consequence in the next cycle
`define WPI_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("wpi check failed");

`endif

// ===== rtl/wpi_pkg.sv =====
package wpi_pkg;

   localparam int IDX_W       = 10;
   localparam int DIST_W      = 42;
   localparam int STEPS_W     = 5;
   localparam logic [STEPS_W-1:0] STEPS_RESET = 5'd10;
   localparam int LANES       = 4;
   localparam int LANE_X      = 0;
   localparam int LANE_Y      = 1;
   localparam int LANE_FRONT  = 2;
   localparam int LANE_REAR   = 3;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef enum logic [1:0] {
      LD_IDLE,
      LD_DIV,
      LD_STEP,
      LD_DONE
   } ld_state_type;

   typedef enum logic [1:0] {
      SC_IDLE,
      SC_SCAN,
      SC_FLUSH
   } sc_state_type;

   // loader status toward the top level
   typedef struct packed {
      logic busy;
      logic wr;
      logic done;
      logic last;
   } ld_status_type;

endpackage

// ===== rtl/wpi_mem.sv =====
module wpi_mem #(
   parameter int DEPTH = 2048,
   parameter int WIDTH = 80
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/wpi_load.sv =====
module wpi_load #(
   parameter int COORD_WIDTH = 20
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          go,
   input  logic                          first,
   input  logic [wpi_pkg::STEPS_W-1:0]   steps,
   input  logic signed [COORD_WIDTH-1:0] pt_x,
   input  logic signed [COORD_WIDTH-1:0] pt_y,
   input  logic signed [COORD_WIDTH-1:0] pt_front,
   input  logic signed [COORD_WIDTH-1:0] pt_rear,
   input  logic                          pt_last,
   output wpi_pkg::ld_status_type        status,
   output logic [4*COORD_WIDTH-1:0]      wr_data
);
   import wpi_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int DCW = $clog2(CW + 1);

   ld_state_type state_ff, state_in;

   logic signed [CW-1:0] cur_ff  [LANES];
   logic signed [CW-1:0] prev_ff [LANES];
   logic signed [CW-1:0] pt_in   [LANES];
   logic                 neg_ff  [LANES];
   logic [CW:0]          dvd_ff  [LANES];
   logic [STEPS_W-1:0]   rem_ff  [LANES];
   logic [CW:0]          qacc_ff [LANES];
   logic [STEPS_W-1:0]   racc_ff [LANES];
   logic [STEPS_W-1:0]   n_ff;
   logic [STEPS_W-1:0]   t_ff;
   logic [DCW-1:0]       dcnt_ff;
   logic                 last_ff;

   assign pt_in[LANE_X]     = pt_x;
   assign pt_in[LANE_Y]     = pt_y;
   assign pt_in[LANE_FRONT] = pt_front;
   assign pt_in[LANE_REAR]  = pt_rear;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         LD_IDLE: begin
            if (go) begin
               state_in = first ? LD_DONE : LD_DIV;
            end
         end
         LD_DIV: begin
            if (dcnt_ff == DCW'(CW)) begin
               state_in = LD_STEP;
            end
         end
         LD_STEP: begin
            if (t_ff == n_ff - STEPS_W'(1)) begin
               state_in = LD_DONE;
            end
         end
         LD_DONE: state_in = LD_IDLE;
         default: state_in = LD_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      status.busy = (state_ff != LD_IDLE);
      status.wr   = (state_ff == LD_STEP);
      status.done = (state_ff == LD_DONE);
      status.last = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= LD_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // shared counters and item capture
   always_ff @(posedge clock) begin
      case (state_ff)
         LD_IDLE: begin
            if (go) begin
               last_ff <= pt_last;
               n_ff    <= (steps == '0) ? STEPS_W'(1) : steps;
               dcnt_ff <= '0;
            end
         end
         LD_DIV: begin
            dcnt_ff <= dcnt_ff + DCW'(1);
            t_ff    <= '0;
         end
         LD_STEP: t_ff <= t_ff + STEPS_W'(1);
         default: ;
      endcase
   end

   // one lane per component: divide |delta| by n, then step the quotient
   for (genvar k = 0; k < LANES; k++) begin : g_lane
      logic signed [CW:0]   delta;
      logic [STEPS_W:0]     shifted;
      logic                 qbit;
      logic [STEPS_W:0]     rsum;
      logic                 wrap;
      logic signed [CW+1:0] value;

      assign delta   = (CW+1)'(pt_in[k]) - (CW+1)'(prev_ff[k]);
      assign shifted = {rem_ff[k], dvd_ff[k][CW]};
      assign qbit    = (shifted >= {1'b0, n_ff});
      assign rsum    = {1'b0, racc_ff[k]} + {1'b0, rem_ff[k]};
      assign wrap    = (rsum >= {1'b0, n_ff});
      assign value   = neg_ff[k] ? ((CW+2)'(prev_ff[k]) - signed'({1'b0, qacc_ff[k]}))
                                 : ((CW+2)'(prev_ff[k]) + signed'({1'b0, qacc_ff[k]}));
      assign wr_data[k*CW +: CW] = value[CW-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            prev_ff[k] <= '0;
         end else if (state_ff == LD_DONE) begin
            prev_ff[k] <= cur_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         case (state_ff)
            LD_IDLE: begin
               if (go) begin
                  cur_ff[k] <= pt_in[k];
                  neg_ff[k] <= delta[CW];
                  dvd_ff[k] <= delta[CW] ? (CW+1)'(-delta) : (CW+1)'(delta);
                  rem_ff[k] <= '0;
               end
            end
            LD_DIV: begin
               if (dcnt_ff != DCW'(CW) || 1'b1) begin
                  rem_ff[k] <= qbit ? STEPS_W'(shifted - {1'b0, n_ff})
                                    : STEPS_W'(shifted);
                  dvd_ff[k] <= {dvd_ff[k][CW-1:0], qbit};
               end
               qacc_ff[k] <= '0;
               racc_ff[k] <= '0;
            end
            LD_STEP: begin
               racc_ff[k] <= wrap ? STEPS_W'(rsum - {1'b0, n_ff}) : STEPS_W'(rsum);
               qacc_ff[k] <= qacc_ff[k] + dvd_ff[k] + (CW+1)'(wrap);
            end
            default: ;
         endcase
      end
   end

endmodule

// ===== rtl/wpi_scan.sv =====
module wpi_scan #(
   parameter int COORD_WIDTH = 20,
   parameter int AW          = 10,
   parameter int CNT_W       = 11
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic                               bank,
   input  logic [CNT_W-1:0]                   count,
   input  logic signed [COORD_WIDTH-1:0]      qx,
   input  logic signed [COORD_WIDTH-1:0]      qy,
   output logic [AW:0]                        rd_addr,
   input  logic [4*COORD_WIDTH-1:0]           rd_data,
   output logic                               busy,
   output logic                               strobe,
   output logic [wpi_pkg::IDX_W-1:0]          nearest_index,
   output logic signed [COORD_WIDTH-1:0]      front_angle,
   output logic signed [COORD_WIDTH-1:0]      rear_angle,
   output logic [wpi_pkg::DIST_W-1:0]         distance_sq
);
   import wpi_pkg::*;

   localparam int CW  = COORD_WIDTH;
   localparam int SQW = 2 * (CW + 1);
   localparam int DW  = SQW + 1;
   localparam int CMW = (DW > DIST_W) ? DW : DIST_W;
   localparam logic [CMW-1:0] DIST_MAX = CMW'({DIST_W{1'b1}});

   sc_state_type state_ff, state_in;

   logic [CNT_W-1:0]     i_ff;
   logic                 bank_ff;
   logic [CNT_W-1:0]     count_ff;
   logic signed [CW-1:0] qx_ff, qy_ff;
   logic                 v1_ff, v2_ff;
   logic [AW-1:0]        idx1_ff, idx2_ff;
   logic [SQW-1:0]       sqx_ff, sqy_ff;
   logic [CW-1:0]        fa2_ff, ra2_ff;
   logic [DW-1:0]        best_d_ff;
   logic [AW-1:0]        best_i_ff;
   logic [CW-1:0]        best_fa_ff, best_ra_ff;

   logic signed [CW:0] dx, dy;
   logic [CW:0]        mx, my;
   logic [DW-1:0]      dist_sum;
   logic [CMW-1:0]     best_wide;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SC_IDLE:  if (go) state_in = SC_SCAN;
         SC_SCAN:  if (i_ff == count_ff - CNT_W'(1)) state_in = SC_FLUSH;
         SC_FLUSH: if (!v1_ff && !v2_ff) state_in = SC_IDLE;
         default:  state_in = SC_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy   = (state_ff != SC_IDLE);
      strobe = (state_ff == SC_FLUSH) && !v1_ff && !v2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SC_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= (state_ff == SC_SCAN);
         v2_ff    <= v1_ff;
      end
   end

   // address issue
   always_ff @(posedge clock) begin
      if (state_ff == SC_IDLE && go) begin
         i_ff     <= '0;
         bank_ff  <= bank;
         count_ff <= count;
         qx_ff    <= qx;
         qy_ff    <= qy;
      end else if (state_ff == SC_SCAN) begin
         i_ff <= i_ff + CNT_W'(1);
      end
      idx1_ff <= i_ff[AW-1:0];
   end

   assign rd_addr = {bank_ff, i_ff[AW-1:0]};

   // stage one: differences and squares
   assign dx = (CW+1)'(qx_ff) - (CW+1)'(signed'(rd_data[LANE_X*CW +: CW]));
   assign dy = (CW+1)'(qy_ff) - (CW+1)'(signed'(rd_data[LANE_Y*CW +: CW]));
   assign mx = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
   assign my = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);

   always_ff @(posedge clock) begin
      sqx_ff  <= SQW'(mx) * SQW'(mx);
      sqy_ff  <= SQW'(my) * SQW'(my);
      fa2_ff  <= rd_data[LANE_FRONT*CW +: CW];
      ra2_ff  <= rd_data[LANE_REAR*CW +: CW];
      idx2_ff <= idx1_ff;
   end

   // stage two: sum and keep the running minimum, first index wins a tie
   assign dist_sum = DW'(sqx_ff) + DW'(sqy_ff);

   always_ff @(posedge clock) begin
      if (v2_ff && (idx2_ff == '0 || dist_sum < best_d_ff)) begin
         best_d_ff  <= dist_sum;
         best_i_ff  <= idx2_ff;
         best_fa_ff <= fa2_ff;
         best_ra_ff <= ra2_ff;
      end
   end

   assign best_wide     = CMW'(best_d_ff);
   assign distance_sq   = (best_wide > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(best_wide);
   assign nearest_index = IDX_W'(best_i_ff);
   assign front_angle   = best_fa_ff;
   assign rear_angle    = best_ra_ff;

endmodule

// ===== rtl/path_interpolate_nearest_waypoint.sv =====
// channel   | ports                         | transfer when
// ----------+-------------------------------+---------------------------
// request   | start, busy, req_*            | start high and busy low
// response  | rsp_strobe, rsp_*             | rsp_strobe high, one cycle
// csr       | csr_valid, csr_ready, csr_wdata | csr_valid and csr_ready
//
// the first point of a path writes no table entry; any other load point
// runs a bit-serial divide of each segment delta, then one table write per
// interpolated point.
// a query makes one table read per entry on the memory's read port; a query
// with no valid path is dropped at once.
// synchronous reset; no clearing pass, the table is only read where written.
// the receiver cannot stall; csr writes are taken while busy is low.
`include "path_interpolate_nearest_waypoint_defines.svh"

module path_interpolate_nearest_waypoint #(
   parameter int MAX_WAYPOINTS = 1024,
   parameter int COORD_WIDTH   = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_mode,
   input  logic signed [COORD_WIDTH-1:0]    req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]    req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]    req_angle_front,
   input  logic signed [COORD_WIDTH-1:0]    req_angle_rear,
   input  logic                             req_last_point,
   output logic                             rsp_strobe,
   output logic [wpi_pkg::IDX_W-1:0]        rsp_nearest_index,
   output logic signed [COORD_WIDTH-1:0]    rsp_front_angle,
   output logic signed [COORD_WIDTH-1:0]    rsp_rear_angle,
   output logic [wpi_pkg::DIST_W-1:0]       rsp_distance_sq,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wpi_pkg::STEPS_W-1:0]      csr_wdata
);
   import wpi_pkg::*;

   localparam int AW    = $clog2(MAX_WAYPOINTS);
   localparam int CNT_W = $clog2(MAX_WAYPOINTS + 1);
   localparam int EW    = 4 * COORD_WIDTH;

   logic [STEPS_W-1:0] steps_ff;
   logic               bank_ff;
   logic               valid_ff;
   logic [1:0]         pts_ff;
   logic [CNT_W-1:0]   shadow_ff;
   logic [CNT_W-1:0]   active_ff;

   ld_status_type ld;
   logic          sc_busy;
   logic          accept, ld_go, sc_go;
   logic          we;
   logic [AW:0]   waddr, raddr;
   logic [EW-1:0] wdata, rdata;

   // request dispatch
   assign busy      = ld.busy | sc_busy;
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign ld_go     = accept && (req_mode == MODE_LOAD);
   assign sc_go     = accept && (req_mode == MODE_QUERY) && valid_ff && (active_ff != '0);

   // csr register
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= STEPS_RESET;
      end else if (csr_valid && csr_ready) begin
         steps_ff <= csr_wdata;
      end
   end

   // shadow write address, dropped past capacity
   assign we    = ld.wr && (shadow_ff < CNT_W'(MAX_WAYPOINTS));
   assign waddr = {~bank_ff, shadow_ff[AW-1:0]};

   // path bookkeeping and bank swap
   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff   <= 1'b0;
         valid_ff  <= 1'b0;
         pts_ff    <= '0;
         shadow_ff <= '0;
         active_ff <= '0;
      end else begin
         if (we) begin
            shadow_ff <= shadow_ff + CNT_W'(1);
         end
         if (ld.done) begin
            if (ld.last) begin
               if (pts_ff != '0) begin
                  bank_ff   <= ~bank_ff;
                  active_ff <= shadow_ff;
                  valid_ff  <= 1'b1;
               end
               pts_ff    <= '0;
               shadow_ff <= '0;
            end else if (pts_ff != 2'd2) begin
               pts_ff <= pts_ff + 2'd1;
            end
         end
      end
   end

   wpi_load #(.COORD_WIDTH(COORD_WIDTH)) u_load (
      .clock    (clock),
      .reset    (reset),
      .go       (ld_go),
      .first    (pts_ff == '0),
      .steps    (steps_ff),
      .pt_x     (req_pos_x),
      .pt_y     (req_pos_y),
      .pt_front (req_angle_front),
      .pt_rear  (req_angle_rear),
      .pt_last  (req_last_point),
      .status   (ld),
      .wr_data  (wdata)
   );

   wpi_mem #(.DEPTH(2 * MAX_WAYPOINTS), .WIDTH(EW)) u_mem (
      .clock   (clock),
      .wr_en   (we),
      .wr_addr (waddr),
      .wr_data (wdata),
      .rd_addr (raddr),
      .rd_data (rdata)
   );

   wpi_scan #(.COORD_WIDTH(COORD_WIDTH), .AW(AW), .CNT_W(CNT_W)) u_scan (
      .clock         (clock),
      .reset         (reset),
      .go            (sc_go),
      .bank          (bank_ff),
      .count         (active_ff),
      .qx            (req_pos_x),
      .qy            (req_pos_y),
      .rd_addr       (raddr),
      .rd_data       (rdata),
      .busy          (sc_busy),
      .strobe        (rsp_strobe),
      .nearest_index (rsp_nearest_index),
      .front_angle   (rsp_front_angle),
      .rear_angle    (rsp_rear_angle),
      .distance_sq   (rsp_distance_sq)
   );

   // checks
   `WPI_ASSERT_NOW(a_rsp_needs_path, clock, reset, rsp_strobe, valid_ff && active_ff != '0)
   `WPI_ASSERT_NOW(a_units_exclusive, clock, reset, ld.busy, !sc_busy)
   `WPI_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_strobe, !rsp_strobe)
   `WPI_ASSERT_NOW(a_write_in_range, clock, reset, we, shadow_ff < CNT_W'(MAX_WAYPOINTS))

endmodule
